// ===== src/bbm_pkg.sv =====
// shared types and constants for the break-before-make speed relay
`timescale 1ns / 1ps

package bbm_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PENDING = 3'd1,
        PH_APPLIED = 3'd2,
        PH_FAILED  = 3'd3,
        PH_FROZEN  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_QUERY     = 3'd1,
        ERR_DISABLED  = 3'd2,
        ERR_NOT_READY = 3'd3,
        ERR_READ      = 3'd4,
        ERR_WRITE     = 3'd5,
        ERR_BAD_STEP  = 3'd6
    } t_err;

    typedef enum logic [1:0] {
        ST_ACTIVE    = 2'd0,
        ST_QUERY_ERR = 2'd1,
        ST_DISABLED  = 2'd2,
        ST_NOT_READY = 2'd3
    } t_status;

    typedef enum logic {
        CMD_TARGET = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    localparam logic [7:0]  CFG_STEP_COUNT = 8'd0;
    localparam logic [7:0]  CFG_BBM_MS     = 8'd1;
    localparam logic [31:0] RETRY_MS       = 32'd1000;
    localparam logic [3:0]  STEP_COUNT_RST = 4'd1;

    typedef struct packed {
        logic [3:0]  step_count;
        logic [15:0] bbm_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] now;
        logic        enabled;
        logic        target_running;
        logic [3:0]  target_step;
        logic [31:0] revision;
        t_status     output_status;
        logic        read_ok;
        logic [7:0]  readback;
        logic        write_ok;
    } t_item;

    typedef struct packed {
        logic        want_running;
        logic [3:0]  want_step;
        logic [31:0] want_revision;
        logic        done_running;
        logic [3:0]  done_step;
        logic        done_valid;
        logic [31:0] done_revision;
        logic        all_off_done;
        logic [31:0] ready_deadline;
        logic [31:0] retry_deadline;
        t_phase      phase;
        t_err        error;
        logic        online;
        logic        obs_valid;
        logic [31:0] change_time;
    } t_state;

    typedef struct packed {
        logic        drive_write;
        logic [7:0]  drive_mask;
        t_phase      phase;
        t_err        error;
        logic        applied_valid;
        logic        applied_running;
        logic [3:0]  applied_step;
        logic        online;
        logic        observed_valid;
        logic [31:0] changed_at;
    } t_result;

endpackage

// ===== src/bbm_step.sv =====
// next-state and result logic for one target or tick beat
`timescale 1ns / 1ps

module bbm_step #(
    parameter int MAX_STEPS = 8
) (
    input  bbm_pkg::t_cfg    i_cfg,
    input  bbm_pkg::t_item   i_item,
    input  bbm_pkg::t_state  i_state,
    output bbm_pkg::t_state  o_state,
    output bbm_pkg::t_result o_result
);

    localparam int CAP = (MAX_STEPS < 8) ? MAX_STEPS : 8;

    function automatic bbm_pkg::t_state f_fail(bbm_pkg::t_state s, bbm_pkg::t_err e,
                                               logic [31:0] now);
        bbm_pkg::t_state r;
        r                = s;
        r.error          = e;
        r.phase          = bbm_pkg::PH_FAILED;
        r.done_valid     = 1'b0;
        r.online         = 1'b0;
        r.obs_valid      = 1'b0;
        r.change_time    = now;
        r.retry_deadline = now + bbm_pkg::RETRY_MS;
        return r;
    endfunction

    function automatic bbm_pkg::t_state f_apply(bbm_pkg::t_state s, logic [31:0] now);
        bbm_pkg::t_state r;
        r               = s;
        r.done_running  = s.want_running;
        r.done_step     = s.want_step;
        r.done_valid    = 1'b1;
        r.done_revision = s.want_revision;
        r.online        = 1'b1;
        r.phase         = bbm_pkg::PH_APPLIED;
        r.error         = bbm_pkg::ERR_NONE;
        r.change_time   = now;
        r.obs_valid     = 1'b1;
        return r;
    endfunction

    logic [3:0]  count;
    logic        have_out;
    logic [7:0]  cnt_mask;
    logic [7:0]  exp_mask;
    logic        match;
    logic [31:0] retry_diff;
    logic [31:0] ready_diff;
    logic        retry_due;
    logic        ready_due;
    logic        just_off;
    logic        go;
    logic        wr_flag;
    logic [7:0]  wr_mask;
    bbm_pkg::t_state n;

    // effective step count, capped by the build-time limit and the 8-bit readback
    assign count    = (i_cfg.step_count > CAP[3:0]) ? CAP[3:0] : i_cfg.step_count;
    assign have_out = (count != 4'd0);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            cnt_mask[i] = (4'(i) < count);
            exp_mask[i] = i_state.want_running && (i_state.want_step == 4'(i));
        end
    end

    assign match      = (((i_item.readback ^ exp_mask) & cnt_mask) == 8'd0);
    assign retry_diff = i_item.now - i_state.retry_deadline;
    assign retry_due  = !retry_diff[31];
    assign ready_diff = i_item.now - i_state.ready_deadline;

    always_comb begin
        n         = i_state;
        wr_flag   = 1'b0;
        wr_mask   = 8'd0;
        go        = 1'b0;
        just_off  = 1'b0;
        ready_due = 1'b0;
        if (i_item.cmd == bbm_pkg::CMD_TARGET) begin
            if (i_item.revision != i_state.want_revision) begin
                n.want_running   = i_item.target_running;
                n.want_step      = i_item.target_step;
                n.want_revision  = i_item.revision;
                n.phase          = bbm_pkg::PH_PENDING;
                n.retry_deadline = 32'd0;
            end
        end else begin
            priority if (have_out && (i_item.output_status != bbm_pkg::ST_ACTIVE)) begin
                n.all_off_done = 1'b0;
                n = f_fail(n, bbm_pkg::t_err'({1'b0, i_item.output_status}), i_item.now);
            end else if (!i_item.enabled) begin
                n.phase = bbm_pkg::PH_FROZEN;
            end else if (retry_due) begin
                go = 1'b1;
                // readback check while the applied command is still current
                if (!n.all_off_done && n.done_valid && (n.done_revision == n.want_revision))
                begin
                    if (have_out && !i_item.read_ok) begin
                        n  = f_fail(n, bbm_pkg::ERR_READ, i_item.now);
                        go = 1'b0;
                    end else if (match) begin
                        n.phase = bbm_pkg::PH_APPLIED;
                        go      = 1'b0;
                    end
                end
                // break phase: everything off
                if (go && !n.all_off_done) begin
                    if (have_out) begin
                        wr_flag = 1'b1;
                        wr_mask = 8'd0;
                        if (!i_item.write_ok) begin
                            n  = f_fail(n, bbm_pkg::ERR_WRITE, i_item.now);
                            go = 1'b0;
                        end
                    end
                    if (go) begin
                        n.done_running   = 1'b0;
                        n.done_step      = n.want_step;
                        n.done_valid     = 1'b1;
                        n.obs_valid      = 1'b1;
                        n.change_time    = i_item.now;
                        n.all_off_done   = 1'b1;
                        n.ready_deadline = i_item.now + {16'd0, i_cfg.bbm_ms};
                        just_off         = 1'b1;
                    end
                end
                // make phase: energise the chosen output
                if (go) begin
                    // a deadline set to now + bbm in this beat is due only when the
                    // interval is zero
                    ready_due = just_off ? (i_cfg.bbm_ms == 16'd0) : !ready_diff[31];
                    if (!n.want_running) begin
                        n              = f_apply(n, i_item.now);
                        n.all_off_done = 1'b0;
                    end else if (ready_due) begin
                        if (n.want_step < count) begin
                            wr_flag = 1'b1;
                            wr_mask = 8'(9'd1 << n.want_step);
                            if (i_item.write_ok) begin
                                n = f_apply(n, i_item.now);
                            end else begin
                                n = f_fail(n, bbm_pkg::ERR_WRITE, i_item.now);
                            end
                            n.all_off_done = 1'b0;
                        end else begin
                            n = f_fail(n, bbm_pkg::ERR_BAD_STEP, i_item.now);
                        end
                    end
                end
            end
        end
    end

    assign o_state = n;

    always_comb begin
        o_result.drive_write     = wr_flag;
        o_result.drive_mask      = wr_mask;
        o_result.phase           = n.phase;
        o_result.error           = n.error;
        o_result.applied_valid   = n.done_valid;
        o_result.applied_running = n.done_running;
        o_result.applied_step    = n.done_step;
        o_result.online          = n.online;
        o_result.observed_valid  = n.obs_valid;
        o_result.changed_at      = n.change_time;
    end

endmodule

// ===== src/break_before_make_speed_relay.sv =====
// top level of the break-before-make multi-speed relay driver
`timescale 1ns / 1ps

// Drives a multi-speed motor through one relay output per speed step. Target
// beats (cmd 0) store a new running flag and step under a revision; a repeated
// revision is ignored. Tick beats (cmd 1) check output availability and the
// enable, then, once the retry deadline is due, verify the relay readback,
// switch every output off, wait break_before_make_ms and energise the one
// chosen output. Failures record an error code and retry 1000 ms later. Every
// beat, target or tick, gives exactly one result beat. The block takes one
// beat per cycle while the skid register is empty: the whole update is a
// single pass of compare and add logic from the state registers to the
// result register. A two-entry output stage (result register plus skid
// register) lets a beat be accepted while a result is still waiting. The
// configuration port is always ready; writes to unknown indexes are dropped.
module break_before_make_speed_relay #(
    parameter int MAX_STEPS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    // input item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_now,
    input  logic        i_enabled,
    input  logic        i_target_running,
    input  logic [3:0]  i_target_step,
    input  logic [31:0] i_revision,
    input  logic [1:0]  i_output_status,
    input  logic        i_read_ok,
    input  logic [7:0]  i_readback,
    input  logic        i_write_ok,

    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_drive_write,
    output logic [7:0]  o_drive_mask,
    output logic [2:0]  o_phase,
    output logic [2:0]  o_error,
    output logic        o_applied_valid,
    output logic        o_applied_running,
    output logic [3:0]  o_applied_step,
    output logic        o_online,
    output logic        o_observed_valid,
    output logic [31:0] o_changed_at
);

    bbm_pkg::t_cfg    r_cfg;
    bbm_pkg::t_state  r_state;
    bbm_pkg::t_state  n_state;
    bbm_pkg::t_item   item;
    bbm_pkg::t_result res;
    bbm_pkg::t_result r_out;
    bbm_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    logic             in_acc;
    logic             out_free;

    // config registers; the user must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_count <= bbm_pkg::STEP_COUNT_RST;
            r_cfg.bbm_ms     <= 16'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bbm_pkg::CFG_STEP_COUNT) begin
                r_cfg.step_count <= i_cfg_data[3:0];
            end else if (i_cfg_index == bbm_pkg::CFG_BBM_MS) begin
                r_cfg.bbm_ms <= i_cfg_data;
            end
        end
    end

    // gather the input beat
    always_comb begin
        item.cmd            = bbm_pkg::t_cmd'(i_cmd);
        item.now            = i_now;
        item.enabled        = i_enabled;
        item.target_running = i_target_running;
        item.target_step    = i_target_step;
        item.revision       = i_revision;
        item.output_status  = bbm_pkg::t_status'(i_output_status);
        item.read_ok        = i_read_ok;
        item.readback       = i_readback;
        item.write_ok       = i_write_ok;
    end

    bbm_step #(
        .MAX_STEPS(MAX_STEPS)
    ) u_step (
        .i_cfg   (r_cfg),
        .i_item  (item),
        .i_state (r_state),
        .o_state (n_state),
        .o_result(res)
    );

    // accept unless the skid register is holding a result
    assign o_ready  = !r_skid_valid;
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // controller state only moves on accepted beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // output register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= res;
            end
        end else if (in_acc) begin
            r_skid <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_drive_write     = r_out.drive_write;
    assign o_drive_mask      = r_out.drive_mask;
    assign o_phase           = r_out.phase;
    assign o_error           = r_out.error;
    assign o_applied_valid   = r_out.applied_valid;
    assign o_applied_running = r_out.applied_running;
    assign o_applied_step    = r_out.applied_step;
    assign o_online          = r_out.online;
    assign o_observed_valid  = r_out.observed_valid;
    assign o_changed_at      = r_out.changed_at;

endmodule

// ===== src/bbm_checker.sv =====
// port-level checks for the speed relay driver and their bind
`timescale 1ns / 1ps

module bbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_drive_write,
    input logic [7:0]  o_drive_mask,
    input logic [2:0]  o_phase,
    input logic [2:0]  o_error,
    input logic        o_applied_valid,
    input logic        o_online,
    input logic [31:0] o_changed_at
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_changed_at) && $stable(o_drive_mask))
        else $error("stalled result changed");

    // energised level is one-hot and only on a write
    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_drive_mask != 8'd0) |-> o_drive_write && $onehot(o_drive_mask))
        else $error("drive mask not one-hot or without write");

    // failed phase always carries an error and drops online
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_phase == bbm_pkg::PH_FAILED) |->
            (o_error != bbm_pkg::ERR_NONE) && !o_online)
        else $error("failed phase without error code");

    // online only with a known applied command
    a_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_online |-> o_applied_valid)
        else $error("online without applied command");

endmodule

bind break_before_make_speed_relay bbm_checker u_bbm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_drive_write  (o_drive_write),
    .o_drive_mask   (o_drive_mask),
    .o_phase        (o_phase),
    .o_error        (o_error),
    .o_applied_valid(o_applied_valid),
    .o_online       (o_online),
    .o_changed_at   (o_changed_at)
);

// ===== tb/bbm_relay_checker.sv =====
// checker that mirrors the relay driver state and compares every result beat
`timescale 1ns / 1ps

module bbm_relay_checker #(
    parameter int MAX_STEPS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [7:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_beat_valid,
    input  logic             i_beat_ready,
    input  bbm_pkg::t_item   i_beat,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  bbm_pkg::t_result i_res,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending,
    output int unsigned      o_checked
);

    bbm_pkg::t_state  relay;
    logic [3:0]       steps_reg;
    logic [15:0]      bbm_reg;
    logic             wr_flag;
    logic [7:0]       wr_mask;
    bbm_pkg::t_result expected_q [$];
    bbm_pkg::t_result head;
    bbm_pkg::t_result pred;
    int unsigned      mismatches = 0;
    int unsigned      compared = 0;

    function automatic logic is_due(logic [31:0] now, logic [31:0] deadline);
        logic [31:0] diff;
        diff = now - deadline;
        return ~diff[31];
    endfunction

    function automatic int unsigned live_steps();
        int unsigned cnt;
        cnt = {28'd0, steps_reg};
        if (cnt > MAX_STEPS) cnt = MAX_STEPS;
        if (cnt > 8) cnt = 8;
        return cnt;
    endfunction

    task automatic mark_failed(bbm_pkg::t_err err, logic [31:0] now);
        relay.error          = err;
        relay.phase          = bbm_pkg::PH_FAILED;
        relay.done_valid     = 1'b0;
        relay.online         = 1'b0;
        relay.obs_valid      = 1'b0;
        relay.change_time    = now;
        relay.retry_deadline = now + bbm_pkg::RETRY_MS;
    endtask

    task automatic mark_applied(logic [31:0] now);
        relay.done_running  = relay.want_running;
        relay.done_step     = relay.want_step;
        relay.done_valid    = 1'b1;
        relay.done_revision = relay.want_revision;
        relay.online        = 1'b1;
        relay.phase         = bbm_pkg::PH_APPLIED;
        relay.error         = bbm_pkg::ERR_NONE;
        relay.change_time   = now;
        relay.obs_valid     = 1'b1;
    endtask

    task automatic relay_tick(bbm_pkg::t_item it);
        int unsigned cnt;
        logic        match;
        cnt = live_steps();
        // availability first, it overrides enable and deadline
        if (cnt > 0 && it.output_status != bbm_pkg::ST_ACTIVE) begin
            relay.all_off_done = 1'b0;
            relay.done_valid   = 1'b0;
            mark_failed(bbm_pkg::t_err'({1'b0, it.output_status}), it.now);
            return;
        end
        if (!it.enabled) begin
            relay.phase = bbm_pkg::PH_FROZEN;
            return;
        end
        if (!is_due(it.now, relay.retry_deadline)) return;

        // current command already applied: verify the readback
        if (!relay.all_off_done && relay.done_valid &&
            relay.done_revision == relay.want_revision) begin
            if (cnt > 0 && !it.read_ok) begin
                mark_failed(bbm_pkg::ERR_READ, it.now);
                return;
            end
            match = 1'b1;
            for (int i = 0; i < cnt; i++) begin
                if (it.readback[i] != (relay.want_running && relay.want_step == 4'(i)))
                    match = 1'b0;
            end
            if (match) begin
                relay.phase = bbm_pkg::PH_APPLIED;
                return;
            end
            relay.all_off_done = 1'b0;
        end

        if (!relay.all_off_done) begin
            if (cnt > 0) begin
                wr_flag = 1'b1;
                wr_mask = 8'h00;
                if (!it.write_ok) begin
                    mark_failed(bbm_pkg::ERR_WRITE, it.now);
                    return;
                end
            end
            relay.done_running   = 1'b0;
            relay.done_step      = relay.want_step;
            relay.done_valid     = 1'b1;
            relay.obs_valid      = 1'b1;
            relay.change_time    = it.now;
            relay.all_off_done   = 1'b1;
            relay.ready_deadline = it.now + {16'd0, bbm_reg};
        end

        if (!relay.want_running) begin
            mark_applied(it.now);
            relay.all_off_done = 1'b0;
            return;
        end
        if (!is_due(it.now, relay.ready_deadline)) return;

        if ({28'd0, relay.want_step} < cnt) begin
            wr_flag = 1'b1;
            wr_mask = 8'd1 << relay.want_step;
            if (it.write_ok) mark_applied(it.now);
            else mark_failed(bbm_pkg::ERR_WRITE, it.now);
            relay.all_off_done = 1'b0;
            return;
        end
        mark_failed(bbm_pkg::ERR_BAD_STEP, it.now);
    endtask

    task automatic predict_beat(bbm_pkg::t_item it, output bbm_pkg::t_result res);
        wr_flag = 1'b0;
        wr_mask = 8'h00;
        if (it.cmd == bbm_pkg::CMD_TARGET) begin
            if (it.revision != relay.want_revision) begin
                relay.want_running   = it.target_running;
                relay.want_step      = it.target_step;
                relay.want_revision  = it.revision;
                relay.phase          = bbm_pkg::PH_PENDING;
                relay.retry_deadline = '0;
            end
        end else begin
            relay_tick(it);
        end
        res.drive_write     = wr_flag;
        res.drive_mask      = wr_mask;
        res.phase           = relay.phase;
        res.error           = relay.error;
        res.applied_valid   = relay.done_valid;
        res.applied_running = relay.done_running;
        res.applied_step    = relay.done_step;
        res.online          = relay.online;
        res.observed_valid  = relay.obs_valid;
        res.changed_at      = relay.change_time;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            relay     = '0;
            steps_reg = bbm_pkg::STEP_COUNT_RST;
            bbm_reg   = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == bbm_pkg::CFG_STEP_COUNT) steps_reg = i_cfg_data[3:0];
                else if (i_cfg_index == bbm_pkg::CFG_BBM_MS) bbm_reg = i_cfg_data;
            end
            // results trail their beat through the output register, so compare before pushing
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end else begin
                    head = expected_q.pop_front();
                    check_field("drive_write", 32'(head.drive_write),
                                32'(i_res.drive_write));
                    check_field("drive_mask", 32'(head.drive_mask), 32'(i_res.drive_mask));
                    check_field("phase", 32'(head.phase), 32'(i_res.phase));
                    check_field("error", 32'(head.error), 32'(i_res.error));
                    check_field("applied_valid", 32'(head.applied_valid),
                                32'(i_res.applied_valid));
                    check_field("applied_running", 32'(head.applied_running),
                                32'(i_res.applied_running));
                    check_field("applied_step", 32'(head.applied_step),
                                32'(i_res.applied_step));
                    check_field("online", 32'(head.online), 32'(i_res.online));
                    check_field("observed_valid", 32'(head.observed_valid),
                                32'(i_res.observed_valid));
                    check_field("changed_at", head.changed_at, i_res.changed_at);
                    compared++;
                end
            end
            if (i_beat_valid && i_beat_ready) begin
                predict_beat(i_beat, pred);
                expected_q.push_back(pred);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_q.size();
        o_checked    <= compared;
    end

endmodule

// ===== tb/break_before_make_speed_relay_tb.sv =====
// testbench top: stimulus, back-pressure and verdict for the speed relay driver
`timescale 1ns / 1ps

module break_before_make_speed_relay_tb;

    // index the block does not decode, its write must be dropped
    localparam logic [7:0] CFG_UNUSED = 8'd2;
    // result register plus skid stage behind the combinational update
    localparam int DRAIN_CYCLES = 6;
    // receiver hold-off long enough to fill the output stage
    localparam int LONG_HOLD = 80;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int N_PHASES = 7;

    logic        clk;
    logic        rst_n;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    logic           beat_valid;
    logic           beat_ready;
    bbm_pkg::t_item beat;

    logic        res_valid;
    logic        res_ready;
    logic        drive_write;
    logic [7:0]  drive_mask;
    logic [2:0]  phase;
    logic [2:0]  error_code;
    logic        applied_valid;
    logic        applied_running;
    logic [3:0]  applied_step;
    logic        online;
    logic        observed_valid;
    logic [31:0] changed_at;
    bbm_pkg::t_result res_bus;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    // stimulus bookkeeping
    int unsigned n_targets = 0;
    int unsigned n_ticks = 0;
    int unsigned n_settings = 0;
    int unsigned stall_req = 0;
    int unsigned stall_served = 0;
    int unsigned burst_left = 0;
    int unsigned cur_steps = 1;
    int unsigned cur_bbm = 0;
    logic [31:0] clock_ms = '0;
    // mirror of the wanted command, only used to shape well-formed readback
    logic        want_run = 1'b0;
    logic [3:0]  want_stp = '0;
    logic [31:0] last_rev = '0;

    break_before_make_speed_relay i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_valid           (beat_valid),
        .o_ready           (beat_ready),
        .i_cmd             (beat.cmd),
        .i_now             (beat.now),
        .i_enabled         (beat.enabled),
        .i_target_running  (beat.target_running),
        .i_target_step     (beat.target_step),
        .i_revision        (beat.revision),
        .i_output_status   (beat.output_status),
        .i_read_ok         (beat.read_ok),
        .i_readback        (beat.readback),
        .i_write_ok        (beat.write_ok),
        .o_valid           (res_valid),
        .i_ready           (res_ready),
        .o_drive_write     (drive_write),
        .o_drive_mask      (drive_mask),
        .o_phase           (phase),
        .o_error           (error_code),
        .o_applied_valid   (applied_valid),
        .o_applied_running (applied_running),
        .o_applied_step    (applied_step),
        .o_online          (online),
        .o_observed_valid  (observed_valid),
        .o_changed_at      (changed_at)
    );

    // same field order as the packed result struct
    assign res_bus = {drive_write, drive_mask, phase, error_code, applied_valid,
                      applied_running, applied_step, online, observed_valid, changed_at};

    bbm_relay_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_beat_valid (beat_valid),
        .i_beat_ready (beat_ready),
        .i_beat       (beat),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 4 ns clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("break_before_make_speed_relay regression: fail");
        $finish;
    end

    // target beat, tick-only fields carry random junk
    function automatic bbm_pkg::t_item make_target(logic [31:0] now, logic run,
                                                   logic [3:0] step, logic [31:0] rev);
        bbm_pkg::t_item it;
        it.cmd            = bbm_pkg::CMD_TARGET;
        it.now            = now;
        it.enabled        = 1'($urandom_range(1, 0));
        it.target_running = run;
        it.target_step    = step;
        it.revision       = rev;
        it.output_status  = bbm_pkg::t_status'(2'($urandom_range(3, 0)));
        it.read_ok        = 1'($urandom_range(1, 0));
        it.readback       = 8'($urandom);
        it.write_ok       = 1'($urandom_range(1, 0));
        return it;
    endfunction

    // tick beat, target-only fields carry random junk
    function automatic bbm_pkg::t_item make_tick(logic [31:0] now, logic en,
                                                 bbm_pkg::t_status status, logic rok,
                                                 logic [7:0] rb, logic wok);
        bbm_pkg::t_item it;
        it.cmd            = bbm_pkg::CMD_TICK;
        it.now            = now;
        it.enabled        = en;
        it.target_running = 1'($urandom_range(1, 0));
        it.target_step    = 4'($urandom_range(15, 0));
        it.revision       = $urandom;
        it.output_status  = status;
        it.read_ok        = rok;
        it.readback       = rb;
        it.write_ok       = wok;
        return it;
    endfunction

    // offer one beat after a random gap, hold it until the block takes it
    task automatic drive_beat(bbm_pkg::t_item it);
        int unsigned gap;
        int unsigned pick;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            pick = $urandom_range(99, 0);
            if (pick < 45) gap = 0;
            else if (pick < 85) gap = $urandom_range(3, 1);
            else if (pick < 97) gap = $urandom_range(8, 4);
            else gap = $urandom_range(40, 15);
        end
        @(negedge clk);
        if (gap != 0) begin
            beat_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        beat       <= it;
        beat_valid <= 1'b1;
        do @(posedge clk); while (!beat_ready);
        if (it.cmd == bbm_pkg::CMD_TARGET) begin
            n_targets++;
            // a repeated revision leaves the wanted command alone
            if (it.revision != last_rev) begin
                want_run = it.target_running;
                want_stp = it.target_step;
                last_rev = it.revision;
            end
        end else begin
            n_ticks++;
        end
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every expected result and let the pipe go quiet
    task automatic settle();
        @(negedge clk);
        beat_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: random ready pattern, plus a long hold-off on request
    initial begin : receiver
        int unsigned pick;
        int unsigned span;
        res_ready = 1'b0;
        forever begin
            if (stall_req != stall_served) begin
                stall_served++;
                @(negedge clk);
                res_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else begin
                pick = $urandom_range(99, 0);
                @(negedge clk);
                if (pick < 60) begin
                    res_ready <= 1'b1;
                    span = $urandom_range(24, 1);
                end else if (pick < 92) begin
                    res_ready <= 1'b0;
                    span = $urandom_range(3, 1);
                end else begin
                    res_ready <= 1'b0;
                    span = $urandom_range(30, 5);
                end
                repeat (span - 1) @(negedge clk);
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_steps [N_PHASES];
        int unsigned phase_bbm [N_PHASES];
        int unsigned pick;
        int unsigned cnt;
        int unsigned adv;
        logic [7:0]  exp_rb;
        logic [7:0]  hi_mask;
        logic [95:0] noise;
        logic [31:0] rev;
        logic [3:0]  stp;
        logic        rb_good;
        bbm_pkg::t_item it;

        // every input known from time zero
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        beat_valid = 1'b0;
        beat       = '0;

        // settings swept per phase, extremes included (zero and above eight steps)
        phase_steps = '{8, 3, 1, 0, 8, 15, 5};
        phase_bbm   = '{0, 250, 60000, 40, 1200, 7, 65535};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        settle();

        // ---- directed part, reset settings: one step, no break time ----
        // first tick after reset: all off then applied while stopped
        drive_beat(make_tick(32'd0, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b1));
        // revision equal to the stored one is ignored
        drive_beat(make_target(32'd5, 1'b1, 4'd0, 32'd0));
        drive_beat(make_target(32'd6, 1'b1, 4'd0, 32'd1));
        // off then on within one tick, mask shows the final one-hot level
        drive_beat(make_tick(32'd10, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b1));
        // readback matches, bits above the step count are ignored
        drive_beat(make_tick(32'd20, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'hFF, 1'b1));
        // readback mismatch forces a fresh break-before-make cycle
        drive_beat(make_tick(32'd30, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b1));
        // failed readback, retry scheduled
        drive_beat(make_tick(32'd40, 1'b1, bbm_pkg::ST_ACTIVE, 1'b0, 8'h01, 1'b1));
        // retry deadline not yet reached
        drive_beat(make_tick(32'd50, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h01, 1'b1));
        // failed write still reports the attempted mask
        drive_beat(make_tick(32'd1040, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b0));
        // availability errors
        drive_beat(make_tick(32'd2040, 1'b1, bbm_pkg::ST_QUERY_ERR, 1'b1, 8'h00, 1'b1));
        drive_beat(make_tick(32'd2041, 1'b1, bbm_pkg::ST_DISABLED, 1'b1, 8'h00, 1'b1));
        drive_beat(make_tick(32'd2042, 1'b1, bbm_pkg::ST_NOT_READY, 1'b1, 8'h00, 1'b1));
        // writes not permitted: frozen
        drive_beat(make_tick(32'd4000, 1'b0, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b1));
        // step index beyond the count: bad step after the all-off write
        drive_beat(make_target(32'd4001, 1'b1, 4'd15, 32'd2));
        drive_beat(make_tick(32'd4002, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b1));
        drive_beat(make_target(32'd4003, 1'b0, 4'd0, 32'hFFFF_FFFF));
        drive_beat(make_tick(32'hFFFF_FFFF, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b1));
        // failed write just before the clock wraps, retry lands after the wrap
        drive_beat(make_target(32'hFFFF_FFFF, 1'b1, 4'd0, 32'h8000_0000));
        drive_beat(make_tick(32'hFFFF_FFFF, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b0));
        drive_beat(make_tick(32'h0000_0100, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b1));
        drive_beat(make_tick(32'h0000_0400, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h00, 1'b1));
        drive_beat(make_tick(32'h0000_0500, 1'b1, bbm_pkg::ST_ACTIVE, 1'b1, 8'h01, 1'b1));
        clock_ms = 32'h0000_0600;

        // ---- random part, one register setting per phase ----
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            cur_steps = phase_steps[ph];
            cur_bbm   = phase_bbm[ph];
            cfg_write(bbm_pkg::CFG_STEP_COUNT, 16'(cur_steps));
            cfg_write(bbm_pkg::CFG_BBM_MS, 16'(cur_bbm));
            if (ph == 2) cfg_write(CFG_UNUSED, 16'hFFFF);
            n_settings++;
            cnt = (cur_steps > 8) ? 8 : cur_steps;
            // one phase runs its clock across the 32-bit wrap
            if (ph == 4) clock_ms = 32'hFFFF_0000;
            // back-pressure: receiver holds off while the sender streams
            if (ph == 1 || ph == 4) begin
                stall_req++;
                burst_left = 40;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99, 0);
                if (pick < 10) begin
                    // noise: every field random
                    noise = {$urandom, $urandom, $urandom};
                    it = noise[$bits(bbm_pkg::t_item)-1:0];
                end else if (pick < 28) begin
                    pick = $urandom_range(99, 0);
                    if (pick < 78) rev = last_rev + 32'd1;
                    else if (pick < 90) rev = last_rev;
                    else rev = $urandom;
                    if ($urandom_range(99, 0) < 80)
                        stp = (cnt == 0) ? 4'd0 : 4'($urandom_range(cnt - 1, 0));
                    else
                        stp = 4'($urandom_range(15, 0));
                    it = make_target(clock_ms, ($urandom_range(99, 0) < 75), stp, rev);
                end else begin
                    // time moves mostly in small steps, sometimes past the break time
                    pick = $urandom_range(99, 0);
                    if (pick < 45) adv = $urandom_range(200, 0);
                    else if (pick < 75) adv = $urandom_range(1500, 200);
                    else if (pick < 92) adv = $urandom_range(cur_bbm + 1500, 0);
                    else if (pick < 97) adv = $urandom_range(70000, 0);
                    else begin
                        clock_ms = $urandom;
                        adv = 0;
                    end
                    clock_ms = clock_ms + adv;

                    exp_rb  = want_run ? (8'd1 << want_stp) : 8'h00;
                    hi_mask = ~((8'd1 << cnt) - 8'd1);
                    rb_good = ($urandom_range(99, 0) < 80);
                    if (rb_good && $urandom_range(1, 0)) exp_rb = exp_rb | (8'($urandom) & hi_mask);
                    if (!rb_good) exp_rb = 8'($urandom);

                    pick = $urandom_range(99, 0);
                    it = make_tick(clock_ms, ($urandom_range(99, 0) < 93),
                                   (pick < 88) ? bbm_pkg::ST_ACTIVE :
                                       bbm_pkg::t_status'(2'($urandom_range(3, 1))),
                                   ($urandom_range(99, 0) < 92), exp_rb,
                                   ($urandom_range(99, 0) < 92));
                end
                drive_beat(it);
            end
        end

        settle();
        $display("run: %0d target and %0d tick beats, %0d register settings, %0d long stalls",
                 n_targets, n_ticks, n_settings, stall_served);
        $display("run: %0d result beats compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("break_before_make_speed_relay regression: pass");
        end else begin
            $display("break_before_make_speed_relay regression: fail");
        end
        $finish;
    end

endmodule
